// ===== rtl/dpad_pkg.sv =====
// Shared types, codes and reset values for the d-pad debounce and auto-repeat block.
`timescale 1ns / 1ps

package dpad_pkg;

  // Channel payload widths
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned EnW       = 6;
  localparam int unsigned NumDir    = 4;
  localparam int unsigned InDataW   = 40;  // 38 field bits padded to whole bytes
  localparam int unsigned OutDataW  = 8;   // 3 field bits padded to whole bytes
  localparam int unsigned CfgAddrW  = 8;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegDebounce = 8'd0;
  localparam logic [CfgAddrW-1:0] RegDelay    = 8'd1;
  localparam logic [CfgAddrW-1:0] RegInterval = 8'd2;
  localparam logic [CfgAddrW-1:0] RegEnable   = 8'd3;

  // Register reset values
  localparam logic [CfgW-1:0] DebounceRst = 16'd20;
  localparam logic [CfgW-1:0] DelayRst    = 16'd400;
  localparam logic [CfgW-1:0] IntervalRst = 16'd100;
  localparam logic [EnW-1:0]  EnableRst   = 6'h3F;

  // Event source codes
  typedef enum logic [2:0] {
    SRC_UP    = 3'd0,
    SRC_DOWN  = 3'd1,
    SRC_LEFT  = 3'd2,
    SRC_RIGHT = 3'd3,
    SRC_CLICK = 3'd4,
    SRC_LONG  = 3'd5
  } src_e;

  // Center gesture codes
  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_CLICK = 2'd1,
    GEST_LONG  = 2'd2,
    GEST_RSVD  = 2'd3
  } gest_e;

  // Per-direction debounce and repeat state
  typedef struct packed {
    logic             raw;
    logic [TimeW-1:0] since;
    logic             pressed;
    logic [TimeW-1:0] next_rpt;
  } lane_state_t;

  // Timing configuration handed to every lane
  typedef struct packed {
    logic [CfgW-1:0] debounce;
    logic [CfgW-1:0] delay;
    logic [CfgW-1:0] interval;
  } lane_cfg_t;

endpackage

// ===== rtl/dpad_lane.sv =====
// One direction: debounce, press edge detection and auto-repeat timing.
`timescale 1ns / 1ps

module dpad_lane import dpad_pkg::*; (
  input  logic [TimeW-1:0] now_i,
  input  logic             raw_i,
  input  logic             repeat_en_i,
  input  lane_cfg_t        cfg_i,
  input  lane_state_t      state_i,
  output lane_state_t      state_o,
  output logic             event_o
);

  logic             raw_chg;
  logic [TimeW-1:0] since_n;
  logic [TimeW-1:0] age;
  logic             pressed;
  logic             edge_hit;
  logic [TimeW-1:0] rpt_diff;
  logic             rpt_hit;
  logic [TimeW-1:0] addend;
  logic [TimeW-1:0] rpt_next;

  // Restart the age whenever the raw level flips
  assign raw_chg = raw_i != state_i.raw;
  assign since_n = raw_chg ? now_i : state_i.since;
  assign age     = now_i - since_n;

  // Accept the raw level once it has been steady long enough (wrapping age)
  assign pressed = (age >= {{(TimeW-CfgW){1'b0}}, cfg_i.debounce}) ? raw_i : state_i.pressed;

  // Press edge, or held key whose repeat time has come (signed difference)
  assign edge_hit = pressed && !state_i.pressed;
  assign rpt_diff = now_i - state_i.next_rpt;
  assign rpt_hit  = pressed && state_i.pressed && repeat_en_i && !rpt_diff[TimeW-1];

  // One adder serves both arming cases
  assign addend   = {{(TimeW-CfgW){1'b0}}, edge_hit ? cfg_i.delay : cfg_i.interval};
  assign rpt_next = now_i + addend;

  always_comb begin
    state_o.raw      = raw_i;
    state_o.since    = since_n;
    state_o.pressed  = pressed;
    state_o.next_rpt = (edge_hit || rpt_hit) ? rpt_next : state_i.next_rpt;
  end

  assign event_o = edge_hit || rpt_hit;

endmodule

// ===== rtl/dpad_debounce_autorepeat.sv =====
// Top level: input register, four direction lanes, priority pick and output register.
`timescale 1ns / 1ps

// Debounced four-way pad with auto-repeat and a center gesture.
// Slave stream s_axis carries one poll per transaction: a millisecond timestamp,
// four raw direction levels and a decoded center gesture. Master stream m_axis
// carries at most one event source code per poll; polls that cause no event
// produce no transaction. Directions are checked up, down, left, right; the
// first one that emits ends the poll and later directions keep their state.
// Timing is set by a plain write port (cfg_we_i / cfg_addr_i / cfg_wdata_i),
// which the user must write only while the block is idle (the block does not
// enforce this): 0 debounce, 1 repeat delay, 2 repeat interval, 3 source
// enable; other indexes are ignored. Throughput: one poll per cycle while no
// event waits on a stalled output. A poll passes one input register, then
// all lane arithmetic in the single stage, then one output register.
// Reset clears all lane state and loads the register defaults.
// When the receiver stalls, the output register holds its event; a polled item
// that produces no event still completes, one that does waits in the input
// register, and s_axis_tready drops only while both registers are occupied.
module dpad_debounce_autorepeat import dpad_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Poll input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] now_time, [32] up_level, [33] down_level, [34] left_level,
  // [35] right_level, [37:36] center_gesture, [39:38] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Event output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] event_source, [7:3] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  // Configuration registers
  logic [CfgW-1:0] debounce_q, delay_q, interval_q;
  logic [EnW-1:0]  enable_q;
  lane_cfg_t       lane_cfg;

  // Input register
  logic                in_valid_q;
  logic [TimeW-1:0]    now_q;
  logic [NumDir-1:0]   raw_q;
  logic [1:0]          gest_q;

  // Lane state and results
  lane_state_t         lane_q [NumDir];
  lane_state_t         lane_d [NumDir];
  logic [NumDir-1:0]   lane_evt;
  logic [NumDir-1:0]   lane_emit;
  logic [NumDir-1:0]   lane_upd;

  // Result selection and output register
  logic                res_valid;
  src_e                res_src;
  logic                advance;
  logic                out_valid_q;
  src_e                out_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      delay_q    <= DelayRst;
      interval_q <= IntervalRst;
      enable_q   <= EnableRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegDebounce: debounce_q <= cfg_wdata_i;
        RegDelay:    delay_q    <= cfg_wdata_i;
        RegInterval: interval_q <= cfg_wdata_i;
        RegEnable:   enable_q   <= cfg_wdata_i[EnW-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg = '{debounce: debounce_q, delay: delay_q, interval: interval_q};

  // Stage advances unless its event would land on a full, stalled output
  assign advance       = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      now_q  <= s_axis_tdata[TimeW-1:0];
      raw_q  <= s_axis_tdata[TimeW+NumDir-1:TimeW];
      gest_q <= s_axis_tdata[TimeW+NumDir+1:TimeW+NumDir];
    end
  end

  // Four lanes work in parallel; up and down auto-repeat
  for (genvar g = 0; g < NumDir; g++) begin : g_lane
    dpad_lane u_lane (
      .now_i       (now_q),
      .raw_i       (raw_q[g]),
      .repeat_en_i (g < 2),
      .cfg_i       (lane_cfg),
      .state_i     (lane_q[g]),
      .state_o     (lane_d[g]),
      .event_o     (lane_evt[g])
    );
    assign lane_emit[g] = lane_evt[g] && enable_q[g];
    // A lane is sampled only if no earlier lane emitted
    if (g == 0) begin : g_first
      assign lane_upd[g] = advance;
    end else begin : g_rest
      assign lane_upd[g] = advance && !(|lane_emit[g-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDir; i++) lane_q[i] <= '0;
    end else begin
      for (int i = 0; i < NumDir; i++) begin
        if (lane_upd[i]) lane_q[i] <= lane_d[i];
      end
    end
  end

  // First emitting direction wins, else the center gesture
  always_comb begin
    res_valid = 1'b0;
    res_src   = SRC_UP;
    if (gest_q == GEST_CLICK && enable_q[SRC_CLICK]) begin
      res_valid = 1'b1;
      res_src   = SRC_CLICK;
    end else if (gest_q == GEST_LONG && enable_q[SRC_LONG]) begin
      res_valid = 1'b1;
      res_src   = SRC_LONG;
    end
    for (int i = NumDir - 1; i >= 0; i--) begin
      if (lane_emit[i]) begin
        res_valid = 1'b1;
        res_src   = src_e'(i[2:0]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) out_src_q <= res_src;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, out_src_q};

  // An event is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |-> (!out_valid_q || m_axis_tready))
    else $error("event written over a pending transaction");

  // At most one direction lane commits an emitting update per poll
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lane_emit & lane_upd))
    else $error("more than one direction emitted in one poll");

  // The up and right lanes only change state while the stage advances
  a_lane_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> (lane_q[0] == $past(lane_q[0]) && lane_q[3] == $past(lane_q[3])))
    else $error("lane state changed without a poll");

  // Emitted codes stay within the defined sources
  a_src_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd5))
    else $error("undefined event source code");

  // A debounce write lands in its register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_addr_i == RegDebounce) |=> (debounce_q == $past(cfg_wdata_i)))
    else $error("debounce register write lost");

endmodule
